### design/fcls_pkg.sv
package fcls_pkg;

    localparam int NUM_BUTTONS = 6;
    localparam int BTN_SOLO    = 4;
    localparam int BTN_MODE    = 5;
    localparam int NUM_SLOTS   = NUM_BUTTONS + 1;

    // register indexes on the configuration port
    localparam logic [1:0] REG_MIN_HOLD   = 2'd0;
    localparam logic [1:0] REG_LONG_HOLD  = 2'd1;
    localparam logic [1:0] REG_COMBO_HOLD = 2'd2;

    localparam logic [15:0] MIN_HOLD_RST   = 16'd50;
    localparam logic [15:0] LONG_HOLD_RST  = 16'd800;
    localparam logic [15:0] COMBO_HOLD_RST = 16'd5000;

    localparam logic [2:0] KIND_PRESET = 3'd0;
    localparam logic [2:0] KIND_EFFECT = 3'd1;
    localparam logic [2:0] KIND_PANEL  = 3'd2;
    localparam logic [2:0] KIND_MODE   = 3'd3;
    localparam logic [2:0] KIND_WIFI   = 3'd4;

    // result slots within one scan: wifi reset first, then button i at slot i+1
    localparam logic [2:0] SLOT_WIFI = 3'd0;
    localparam logic [2:0] SLOT_SOLO = 3'd5;
    localparam logic [2:0] SLOT_MODE = 3'd6;

    typedef struct packed {
        logic held;
        logic rel_fire;
        logic long_fire;
        logic combo_met;
    } t_lane_evt;

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] value;
    } t_action;

    function automatic t_action slot_action(input logic [2:0] slot, input logic mode,
                                            input logic mode_rel);
        t_action a;
        a.kind  = KIND_WIFI;
        a.value = 2'd0;
        unique case (slot)
            SLOT_WIFI: begin
                a.kind  = KIND_WIFI;
                a.value = 2'd0;
            end
            SLOT_SOLO: begin
                a.kind  = KIND_PANEL;
                a.value = 2'd0;
            end
            SLOT_MODE: begin
                a.kind  = KIND_MODE;
                a.value = {1'b0, mode_rel};
            end
            3'd1, 3'd2, 3'd3, 3'd4: begin
                a.kind  = mode ? KIND_EFFECT : KIND_PRESET;
                a.value = 2'(slot - 3'd1);
            end
            default: begin
                a.kind  = KIND_WIFI;
                a.value = 2'd0;
            end
        endcase
        return a;
    endfunction

endpackage

### design/fcls_lane.sv
module fcls_lane #(
    parameter int TW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [TW-1:0]        i_now,
    input  logic                 i_down,
    input  logic [15:0]          i_min_hold,
    input  logic [15:0]          i_long_hold,
    input  logic [15:0]          i_combo_hold,
    input  logic                 i_combo_set,
    input  logic                 i_combo_block,
    output fcls_pkg::t_lane_evt  o_evt
);

    logic          r_held;
    logic          r_long;
    logic [TW-1:0] r_stamp;
    logic          n_held;
    logic          n_long;

    logic [TW-1:0] elapsed;
    logic          long_eff;
    logic          met_min;
    logic          met_long;

    assign elapsed  = i_now - r_stamp;
    assign met_min  = elapsed >= TW'(i_min_hold);
    assign met_long = elapsed >= TW'(i_long_hold);
    assign long_eff = r_long | i_combo_set;

    always_comb begin
        o_evt.held      = r_held;
        o_evt.combo_met = elapsed >= TW'(i_combo_hold);
        o_evt.rel_fire  = !i_down && r_held && !long_eff && met_min && !i_combo_block;
        o_evt.long_fire = i_down && r_held && !long_eff && met_long;
    end

    always_comb begin
        n_held = i_down;
        n_long = long_eff;
        if (i_down && !r_held) begin
            n_long = 1'b0;
        end else if (i_down && r_held) begin
            n_long = long_eff | met_long;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
            r_long <= 1'b0;
        end else if (i_take) begin
            r_held <= n_held;
            r_long <= n_long;
        end
    end

    // stamp is only read while held, and a press always loads it
    always_ff @(posedge i_clk) begin
        if (i_take && i_down && !r_held) begin
            r_stamp <= i_now;
        end
    end

endmodule

### design/fcls_emit.sv
module fcls_emit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic [fcls_pkg::NUM_SLOTS-1:0]    i_mask,
    input  logic                              i_mode,
    input  logic                              i_mode_rel,
    output logic                              o_can_load,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [2:0]                        o_action_kind,
    output logic [1:0]                        o_action_value,
    output logic                              o_last_action
);

    localparam int NS = fcls_pkg::NUM_SLOTS;

    logic [NS-1:0] r_pend;
    logic          r_mode;
    logic          r_mode_rel;
    logic [NS-1:0] low_bit;
    logic [NS-1:0] rest;
    logic [2:0]    slot;
    logic          out_fire;
    fcls_pkg::t_action act;

    assign low_bit = r_pend & (~r_pend + NS'(1));
    assign rest    = r_pend & ~low_bit;

    always_comb begin
        slot = 3'd0;
        for (int k = 0; k < NS; k++) begin
            if (low_bit[k]) begin
                slot = 3'(k);
            end
        end
    end

    assign act            = fcls_pkg::slot_action(slot, r_mode, r_mode_rel);
    assign o_out_valid    = |r_pend;
    assign o_action_kind  = act.kind;
    assign o_action_value = act.value;
    assign o_last_action  = ~|rest;
    assign out_fire       = o_out_valid && i_out_ready;
    // take the next scan once the last beat of this one leaves
    assign o_can_load     = !o_out_valid || (out_fire && o_last_action);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (i_load) begin
            r_pend <= i_mask;
        end else if (out_fire) begin
            r_pend <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mode     <= i_mode;
            r_mode_rel <= i_mode_rel;
        end
    end

endmodule

### design/footswitch_press_classifier.sv
// channel  | direction | handshake                  | payload
// cfg      | in        | i_cfg_we                   | i_cfg_idx, i_cfg_data
// scan     | in        | i_in_valid / o_in_ready    | i_now_ms, i_button_levels,
//          |           |                            | i_footswitch_mode
// action   | out       | o_out_valid / i_out_ready  | o_action_kind, o_action_value,
//          |           |                            | o_last_action
//
// Six button lanes evaluate a scan in the cycle it is accepted; state updates then.
// A scan causing actions occupies the action buffer until its last beat leaves (one
// beat a cycle while i_out_ready is high); a scan with no action never enters it.
// The next scan is taken in the cycle the last beat of the previous one leaves.
// Reset is synchronous: flags, the combo mark and the buffer clear, thresholds
// return to 50/800/5000 ms. A stalled output holds the buffer and scan input.
module footswitch_press_classifier #(
    parameter int TIME_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_now_ms,
    input  logic [5:0]  i_button_levels,
    input  logic        i_footswitch_mode,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_action_kind,
    output logic [1:0]  o_action_value,
    output logic        o_last_action
);

    localparam int NB = fcls_pkg::NUM_BUTTONS;
    localparam int NS = fcls_pkg::NUM_SLOTS;

    logic [15:0] r_min_hold;
    logic [15:0] r_long_hold;
    logic [15:0] r_combo_hold;
    logic        r_combo_fired;
    logic        n_combo_fired;

    fcls_pkg::t_lane_evt evt [NB];
    logic [NB-1:0] down;
    logic          take;
    logic          combo_now;
    logic          combo_eff;
    logic [NS-1:0] mask;

    assign down      = ~i_button_levels;
    assign take      = i_in_valid && o_in_ready;
    assign combo_now = evt[fcls_pkg::BTN_MODE].held && evt[fcls_pkg::BTN_SOLO].held
                       && !r_combo_fired
                       && evt[fcls_pkg::BTN_MODE].combo_met
                       && evt[fcls_pkg::BTN_SOLO].combo_met;
    assign combo_eff = r_combo_fired || combo_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_hold   <= fcls_pkg::MIN_HOLD_RST;
            r_long_hold  <= fcls_pkg::LONG_HOLD_RST;
            r_combo_hold <= fcls_pkg::COMBO_HOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fcls_pkg::REG_MIN_HOLD:   r_min_hold   <= i_cfg_data;
                fcls_pkg::REG_LONG_HOLD:  r_long_hold  <= i_cfg_data;
                fcls_pkg::REG_COMBO_HOLD: r_combo_hold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < NB; g++) begin : g_lane
        fcls_lane #(
            .TW (TIME_BITS)
        ) u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_take        (take),
            .i_now         (i_now_ms[TIME_BITS-1:0]),
            .i_down        (down[g]),
            .i_min_hold    (r_min_hold),
            .i_long_hold   (r_long_hold),
            .i_combo_hold  (r_combo_hold),
            .i_combo_set   (combo_now && (g == fcls_pkg::BTN_SOLO || g == fcls_pkg::BTN_MODE)),
            .i_combo_block (combo_eff),
            .o_evt         (evt[g])
        );
    end

    // slot 0 is the wifi reset; only MODE turns a long press into an action
    always_comb begin
        mask[0] = combo_now;
        for (int k = 0; k < NB; k++) begin
            mask[k+1] = evt[k].rel_fire;
        end
        mask[fcls_pkg::BTN_MODE+1] = evt[fcls_pkg::BTN_MODE].rel_fire
                                     || evt[fcls_pkg::BTN_MODE].long_fire;
    end

    // drop the combo mark once both MODE and SOLO are up
    assign n_combo_fired = combo_eff
                           && (down[fcls_pkg::BTN_MODE] || down[fcls_pkg::BTN_SOLO]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_combo_fired <= 1'b0;
        end else if (take) begin
            r_combo_fired <= n_combo_fired;
        end
    end

    fcls_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (take && (|mask)),
        .i_mask         (mask),
        .i_mode         (i_footswitch_mode),
        .i_mode_rel     (evt[fcls_pkg::BTN_MODE].rel_fire),
        .o_can_load     (o_in_ready),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_action_kind  (o_action_kind),
        .o_action_value (o_action_value),
        .o_last_action  (o_last_action)
    );

endmodule

### dv/footswitch_press_classifier_chk.sv
`timescale 1ns / 1ps

module footswitch_press_classifier_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_now_ms,
    input  logic [5:0]  i_button_levels,
    input  logic        i_footswitch_mode,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_action_kind,
    input  logic [1:0]  i_action_value,
    input  logic        i_last_action,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] value;
        logic       last;
    } t_act_beat;

    logic [15:0] min_hold;
    logic [15:0] long_hold;
    logic [15:0] combo_hold;

    logic [5:0]  held_mask;
    logic [5:0]  long_done_mask;
    logic [31:0] press_stamp [fcls_pkg::NUM_BUTTONS];
    logic        combo_latched;

    t_act_beat   expected_actions [$];
    t_act_beat   seen_beat;
    t_act_beat   want_beat;
    int          r;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_act_beat make_beat(input logic [2:0] kind, input logic [1:0] value);
        t_act_beat a;
        a.kind  = kind;
        a.value = value;
        a.last  = 1'b0;
        return a;
    endfunction

    task automatic report_mismatch(input string what, input t_act_beat got,
                                   input t_act_beat want);
        $display("%0t ns: %s: kind %0d value %0d last %0b, expected kind %0d value %0d last %0b",
                 $time, what, got.kind, got.value, got.last, want.kind, want.value, want.last);
        o_fail_count = o_fail_count + 1;
    endtask

    // Work out every action one scan causes and queue them in order.
    task automatic predict_scan(input logic [31:0] now, input logic [5:0] levels,
                                input logic mode);
        t_act_beat   scan_beats [$];
        logic [31:0] age;
        logic [31:0] age_mode;
        logic [31:0] age_solo;
        logic        pressed;
        int          b;
        age_mode = now - press_stamp[fcls_pkg::BTN_MODE];
        age_solo = now - press_stamp[fcls_pkg::BTN_SOLO];
        if (held_mask[fcls_pkg::BTN_MODE] && held_mask[fcls_pkg::BTN_SOLO]
                && !combo_latched) begin
            if (age_mode >= 32'(combo_hold) && age_solo >= 32'(combo_hold)) begin
                combo_latched                      = 1'b1;
                long_done_mask[fcls_pkg::BTN_MODE] = 1'b1;
                long_done_mask[fcls_pkg::BTN_SOLO] = 1'b1;
                scan_beats.push_back(make_beat(fcls_pkg::KIND_WIFI, 2'd0));
            end
        end
        for (b = 0; b < fcls_pkg::NUM_BUTTONS; b++) begin
            pressed = !levels[b];
            age     = now - press_stamp[b];
            if (pressed && !held_mask[b]) begin
                held_mask[b]      = 1'b1;
                long_done_mask[b] = 1'b0;
                press_stamp[b]    = now;
            end else if (!pressed && held_mask[b]) begin
                held_mask[b] = 1'b0;
                if (!long_done_mask[b] && age >= 32'(min_hold) && !combo_latched) begin
                    if (b < fcls_pkg::BTN_SOLO) begin
                        scan_beats.push_back(make_beat(
                            mode ? fcls_pkg::KIND_EFFECT : fcls_pkg::KIND_PRESET, 2'(b)));
                    end else if (b == fcls_pkg::BTN_SOLO) begin
                        scan_beats.push_back(make_beat(fcls_pkg::KIND_PANEL, 2'd0));
                    end else begin
                        scan_beats.push_back(make_beat(fcls_pkg::KIND_MODE, 2'd1));
                    end
                end
            end else if (pressed && held_mask[b] && !long_done_mask[b]) begin
                if (age >= 32'(long_hold)) begin
                    long_done_mask[b] = 1'b1;
                    // only MODE reports a long press; the others just go quiet
                    if (b == fcls_pkg::BTN_MODE) begin
                        scan_beats.push_back(make_beat(fcls_pkg::KIND_MODE, 2'd0));
                    end
                end
            end
        end
        if (combo_latched && !held_mask[fcls_pkg::BTN_MODE]
                && !held_mask[fcls_pkg::BTN_SOLO]) begin
            combo_latched = 1'b0;
        end
        if (scan_beats.size() > 0) begin
            scan_beats[scan_beats.size() - 1].last = 1'b1;
        end
        for (b = 0; b < scan_beats.size(); b++) begin
            expected_actions.push_back(scan_beats[b]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            min_hold       = fcls_pkg::MIN_HOLD_RST;
            long_hold      = fcls_pkg::LONG_HOLD_RST;
            combo_hold     = fcls_pkg::COMBO_HOLD_RST;
            held_mask      = '0;
            long_done_mask = '0;
            combo_latched  = 1'b0;
            for (r = 0; r < fcls_pkg::NUM_BUTTONS; r++) begin
                press_stamp[r] = '0;
            end
            expected_actions.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fcls_pkg::REG_MIN_HOLD:   min_hold   = i_cfg_data;
                    fcls_pkg::REG_LONG_HOLD:  long_hold  = i_cfg_data;
                    fcls_pkg::REG_COMBO_HOLD: combo_hold = i_cfg_data;
                    default: ;
                endcase
            end
            // check the leaving beat before queueing a new scan: it belongs to an older one
            if (i_out_valid && i_out_ready) begin
                seen_beat.kind  = i_action_kind;
                seen_beat.value = i_action_value;
                seen_beat.last  = i_last_action;
                if (expected_actions.size() == 0) begin
                    report_mismatch("action with none expected", seen_beat, '0);
                end else begin
                    want_beat = expected_actions.pop_front();
                    if (seen_beat.kind !== want_beat.kind || seen_beat.value !== want_beat.value
                            || seen_beat.last !== want_beat.last) begin
                        report_mismatch("action differs", seen_beat, want_beat);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_scan(i_now_ms, i_button_levels, i_footswitch_mode);
            end
        end
        o_pending = expected_actions.size();
    end

endmodule

### dv/footswitch_press_classifier_tb.sv
`timescale 1ns / 1ps

module footswitch_press_classifier_tb;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 7;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int PHASE_SCANS     = 78;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = fcls_pkg::REG_MIN_HOLD;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] now_ms = '0;
    logic [5:0]  button_levels = 6'h3F;
    logic        fs_mode = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  action_kind;
    logic [1:0]  action_value;
    logic        last_action;

    int          fail_count;
    int          pending;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;

    // scan generator state: time, pin levels, and a mask of pins kept down for a while
    logic [31:0] gen_now = '0;
    logic [5:0]  gen_levels = 6'h3F;
    logic        gen_mode = 1'b0;
    logic [5:0]  pin_hold_mask = '0;
    int          pin_hold_scans = 0;

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    footswitch_press_classifier u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_now_ms          (now_ms),
        .i_button_levels   (button_levels),
        .i_footswitch_mode (fs_mode),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_action_kind     (action_kind),
        .o_action_value    (action_value),
        .o_last_action     (last_action)
    );

    footswitch_press_classifier_chk u_chk (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_now_ms          (now_ms),
        .i_button_levels   (button_levels),
        .i_footswitch_mode (fs_mode),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_action_kind     (action_kind),
        .i_action_value    (action_value),
        .i_last_action     (last_action),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // Action receiver: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        forever begin
            @(negedge clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_served + 1;
                hold_left   = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Offer one scan and hold it until the beat is taken.
    task automatic send_scan(input logic [31:0] now, input logic [5:0] levels, input logic mode);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        now_ms        <= now;
        button_levels <= levels;
        fs_mode       <= mode;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
    endtask

    // Drop valid and wait until every queued action has left the block.
    task automatic drain_actions();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_regs(input logic [15:0] min_ms, input logic [15:0] long_ms,
                              input logic [15:0] combo_ms);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= fcls_pkg::REG_MIN_HOLD;
        cfg_data <= min_ms;
        @(negedge clk);
        cfg_idx  <= fcls_pkg::REG_LONG_HOLD;
        cfg_data <= long_ms;
        @(negedge clk);
        cfg_idx  <= fcls_pkg::REG_COMBO_HOLD;
        cfg_data <= combo_ms;
        // an unused index must leave the thresholds alone
        @(negedge clk);
        cfg_idx  <= REG_UNUSED;
        cfg_data <= 16'($urandom());
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Advance time and pin levels the way a player would, with the odd wild scan.
    task automatic next_scan(input int step_max);
        int b;
        if ($urandom_range(0, 24) == 0) begin
            gen_now = $urandom();
        end else begin
            gen_now = gen_now + $urandom_range(0, step_max);
        end
        if ($urandom_range(0, 39) == 0) begin
            gen_levels = 6'($urandom());
        end else begin
            for (b = 0; b < fcls_pkg::NUM_BUTTONS; b++) begin
                if ($urandom_range(0, 5) == 0) begin
                    gen_levels[b] = ~gen_levels[b];
                end
            end
        end
        if (pin_hold_scans > 0) begin
            gen_levels     = gen_levels & ~pin_hold_mask;
            pin_hold_scans = pin_hold_scans - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            pin_hold_scans = $urandom_range(4, 24);
            case ($urandom_range(0, 2))
                0:       pin_hold_mask = 6'b110000;
                1:       pin_hold_mask = 6'b100000;
                default: pin_hold_mask =
                             6'(1 << $urandom_range(0, fcls_pkg::NUM_BUTTONS - 1));
            endcase
        end
        if ($urandom_range(0, 9) == 0) begin
            gen_mode = ~gen_mode;
        end
    endtask

    task automatic run_phase(input logic [15:0] min_ms, input logic [15:0] long_ms,
                             input logic [15:0] combo_ms, input int send_pct,
                             input int recv_pct, input int step_max, input bit hold_off);
        int n;
        drain_actions();
        write_regs(min_ms, long_ms, combo_ms);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        // block the receiver while the sender keeps pushing scans
        if (hold_off) begin
            hold_requests = hold_requests + 1;
        end
        for (n = 0; n < PHASE_SCANS; n++) begin
            next_scan(step_max);
            send_scan(gen_now, gen_levels, gen_mode);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed scans on the reset thresholds of 50, 800 and 5000 ms
        send_scan(32'd0, 6'h3F, 1'b0);
        send_scan(32'd100, 6'h00, 1'b0);
        send_scan(32'd200, 6'h0F, 1'b0);
        send_scan(32'd220, 6'h00, 1'b1);
        send_scan(32'd300, 6'h0F, 1'b1);
        send_scan(32'd950, 6'h0F, 1'b1);
        send_scan(32'd5200, 6'h0F, 1'b1);
        send_scan(32'd5300, 6'h3F, 1'b0);
        send_scan(32'd5310, 6'h1F, 1'b0);
        send_scan(32'd5400, 6'h3F, 1'b0);
        send_scan(32'd5410, 6'h2F, 1'b0);
        send_scan(32'd5500, 6'h3F, 1'b0);
        // release too early to count
        send_scan(32'd5510, 6'h3E, 1'b0);
        send_scan(32'd5520, 6'h3F, 1'b0);
        // hold across the wrap of the time counter
        send_scan(32'hFFFF_FFF0, 6'h3D, 1'b0);
        send_scan(32'h0000_0050, 6'h3F, 1'b0);
        // time running backwards
        send_scan(32'h0000_0040, 6'h3B, 1'b0);
        send_scan(32'h0000_0030, 6'h3F, 1'b0);
        // combo, then a release swallowed while it is latched
        send_scan(32'h0000_0100, 6'h0E, 1'b0);
        send_scan(32'h0000_0100 + 32'd5000, 6'h0E, 1'b0);
        send_scan(32'h0000_0100 + 32'd5010, 6'h0F, 1'b1);
        send_scan(32'h0000_0100 + 32'd5020, 6'h0E, 1'b1);
        send_scan(32'h0000_0100 + 32'd5120, 6'h0F, 1'b1);
        send_scan(32'h0000_0100 + 32'd5200, 6'h3F, 1'b1);
        send_scan(32'h0000_0100 + 32'd5300, 6'h3E, 1'b1);
        send_scan(32'h0000_0100 + 32'd5400, 6'h3F, 1'b1);

        run_phase(16'd20, 16'd120, 16'd400, 0, 0, 40, 1'b0);
        run_phase(16'd0, 16'd0, 16'd0, 85, 0, 40, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 85, 20000, 1'b0);
        run_phase(16'($urandom_range(0, 60)), 16'($urandom_range(60, 250)),
                  16'($urandom_range(250, 700)), 36, 36, 40, 1'b0);
        run_phase(16'($urandom_range(0, 60)), 16'($urandom_range(60, 250)),
                  16'($urandom_range(250, 700)), 0, 0, 40, 1'b1);

        drain_actions();
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("timeout with %0d actions outstanding", pending);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
